// ===== hdl/ese_pkg.sv =====
// Package for the exchange sort engine: depth, widths and transaction types.
// No dependencies; used by ese_cell and exchange_sort_engine_top.
package ese_pkg;

  localparam int unsigned Depth  = 16;
  localparam int unsigned DataW  = 32;
  localparam int unsigned CountW = $clog2(Depth + 1);

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    last_in;
  } in_t;

  typedef struct packed {
    logic signed [DataW-1:0] sorted_value;
    logic                    last_out;
    logic                    overflow;
  } out_t;

  // Broadcast control from the top level to every cell.
  typedef struct packed {
    logic                    insert;
    logic                    shift;
    logic signed [DataW-1:0] value;
  } cell_ctl_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    logic                    vld;
    logic                    gt;
    logic signed [DataW-1:0] val;
  } cell_stat_t;

endpackage

// ===== hdl/ese_cell.sv =====
// One compare-and-hold cell of the sorting chain.
// Depends on ese_pkg.
module ese_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ese_pkg::cell_ctl_t    ctl_i,
  input  logic                  first_i,  // cell at the head of the chain
  input  ese_pkg::cell_stat_t   prev_i,
  input  ese_pkg::cell_stat_t   next_i,
  output ese_pkg::cell_stat_t   stat_o
);

  logic                             vld_q, vld_d;
  logic signed [ese_pkg::DataW-1:0] val_q, val_d;
  logic                             gt;
  logic                             prev_gt;

  // New value belongs at or before this cell; equal values stay ahead.
  assign gt      = !vld_q || (val_q > ctl_i.value);
  assign prev_gt = !first_i && prev_i.gt;

  always_comb begin
    vld_d = vld_q;
    val_d = val_q;
    if (ctl_i.shift) begin
      vld_d = next_i.vld;
      val_d = next_i.val;
    end else if (ctl_i.insert && gt) begin
      if (!prev_gt) begin
        vld_d = 1'b1;
        val_d = ctl_i.value;
      end else begin
        vld_d = prev_i.vld;
        val_d = prev_i.val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign stat_o.vld = vld_q;
  assign stat_o.gt  = gt;
  assign stat_o.val = val_q;

endmodule

// ===== hdl/exchange_sort_engine_top.sv =====
// Top level of the exchange sort engine: a chain of ese_cell instances.
// Depends on ese_pkg and ese_cell.
//
// The engine collects one set of signed 32-bit values, one input transaction
// per cycle, and keeps them in ascending order in a chain of Depth cells:
// each new value is compared against every cell at once, and the cells at
// and after its place move one step down the chain while it drops in.
// Equal values keep their arrival order. Values after the first Depth of a
// set are dropped and every result of that set carries the overflow flag.
// The transaction with last_in set ends the set; from then on the input is
// not ready while the chain drains from its head, one result per accepted
// output transaction, the final one marked with last_out. The drained result
// sits in the head cell, which acts as output register.
module exchange_sort_engine_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ese_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ese_pkg::out_t out_data_o
);

  logic                         drain_q, drain_d;
  logic                         ovf_q, ovf_d;
  logic [ese_pkg::CountW-1:0]   count_q, count_d;
  logic                         in_acc, out_acc, full, final_out;
  ese_pkg::cell_ctl_t           ctl;
  ese_pkg::cell_stat_t          stat [ese_pkg::Depth];

  assign in_ready_o  = !drain_q;
  assign out_valid_o = drain_q;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_o && out_ready_i;
  assign full        = (count_q == ese_pkg::CountW'(ese_pkg::Depth));
  assign final_out   = (count_q == ese_pkg::CountW'(1));

  assign ctl.insert = in_acc && !full;
  assign ctl.shift  = out_acc;
  assign ctl.value  = in_data_i.value;

  // Chain of cells; the head takes no left neighbor, the tail sees an empty right one.
  for (genvar i = 0; i < ese_pkg::Depth; i++) begin : g_cell
    ese_pkg::cell_stat_t prev_s, next_s;
    if (i == 0) begin : g_head
      assign prev_s = '0;
    end else begin : g_body
      assign prev_s = stat[i-1];
    end
    if (i == ese_pkg::Depth - 1) begin : g_tail
      assign next_s = '0;
    end else begin : g_inner
      assign next_s = stat[i+1];
    end
    ese_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .first_i (i == 0),
      .prev_i  (prev_s),
      .next_i  (next_s),
      .stat_o  (stat[i])
    );
  end

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    drain_d = drain_q;
    if (ctl.insert) begin
      count_d = count_q + ese_pkg::CountW'(1);
    end
    if (in_acc && full) begin
      ovf_d = 1'b1;
    end
    if (in_acc && in_data_i.last_in) begin
      drain_d = 1'b1;
    end
    if (out_acc) begin
      count_d = count_q - ese_pkg::CountW'(1);
      if (final_out) begin
        drain_d = 1'b0;
        ovf_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q <= 1'b0;
      ovf_q   <= 1'b0;
      count_q <= '0;
    end else begin
      drain_q <= drain_d;
      ovf_q   <= ovf_d;
      count_q <= count_d;
    end
  end

  assign out_data_o.sorted_value = stat[0].val;
  assign out_data_o.last_out     = final_out;
  assign out_data_o.overflow     = ovf_q;

endmodule

// ===== tb/ese_checker.sv =====
// Scoreboard for the exchange sort engine: watches both channels, predicts
// the sorted output of each set and compares it. Depends on ese_pkg.
module ese_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  ese_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  ese_pkg::out_t out_data_i,
  output int            fail_cnt_o,
  output int            pending_o,
  output int            results_o,
  output int            sets_o,
  output int            trimmed_sets_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Current set as the engine should be holding it.
  logic signed [ese_pkg::DataW-1:0] held [ese_pkg::Depth];
  int   held_n  = 0;
  logic dropped = 1'b0;

  ese_pkg::out_t sorted_results_q [$];

  int fail_cnt     = 0;
  int results      = 0;
  int sets         = 0;
  int trimmed_sets = 0;

  task automatic report(input string msg);
    $display("[%0t] MISMATCH %s", $realtime, msg);
    fail_cnt++;
  endtask

  // Stable ascending insertion sort; equal values keep arrival order.
  function automatic void sort_held();
    logic signed [ese_pkg::DataW-1:0] key;
    int j;
    for (int i = 1; i < held_n; i++) begin
      key = held[i];
      j   = i;
      while (j > 0 && held[j-1] > key) begin
        held[j] = held[j-1];
        j--;
      end
      held[j] = key;
    end
  endfunction

  task automatic take_item(input ese_pkg::in_t item);
    if (held_n < ese_pkg::Depth) begin
      held[held_n] = item.value;
      held_n++;
    end else begin
      dropped = 1'b1;
    end
    if (item.last_in) begin
      sort_held();
      for (int k = 0; k < held_n; k++) begin
        sorted_results_q.push_back('{sorted_value: held[k],
                                     last_out:     (k == held_n - 1),
                                     overflow:     dropped});
      end
      sets++;
      if (dropped) trimmed_sets++;
      held_n  = 0;
      dropped = 1'b0;
    end
  endtask

  task automatic check_result(input ese_pkg::out_t got);
    ese_pkg::out_t exp;
    results++;
    if (sorted_results_q.size() == 0) begin
      report($sformatf("unexpected result value=%0d last=%0b ovf=%0b",
                       got.sorted_value, got.last_out, got.overflow));
    end else begin
      exp = sorted_results_q.pop_front();
      if (got.sorted_value !== exp.sorted_value)
        report($sformatf("sorted_value got %0d exp %0d",
                         got.sorted_value, exp.sorted_value));
      if (got.last_out !== exp.last_out)
        report($sformatf("last_out got %0b exp %0b (value %0d)",
                         got.last_out, exp.last_out, exp.sorted_value));
      if (got.overflow !== exp.overflow)
        report($sformatf("overflow got %0b exp %0b (value %0d)",
                         got.overflow, exp.overflow, exp.sorted_value));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_n  = 0;
      dropped = 1'b0;
      sorted_results_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) check_result(out_data_i);
      if (in_valid_i && in_ready_i) take_item(in_data_i);
    end
    fail_cnt_o     <= fail_cnt;
    pending_o      <= sorted_results_q.size();
    results_o      <= results;
    sets_o         <= sets;
    trimmed_sets_o <= trimmed_sets;
  end

endmodule

// ===== tb/tb_exchange_sort_engine_top.sv =====
// Top of the exchange sort engine testbench: clock, reset, bursty stimulus
// and a stalling receiver. Depends on ese_pkg, exchange_sort_engine_top, ese_checker.
module tb_exchange_sort_engine_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ItemTarget   = 460;
  // Wait after the last expected result, longer than the drain of a full chain.
  localparam int SettleCycles = 2 * ese_pkg::Depth + 8;

  localparam logic signed [ese_pkg::DataW-1:0] ValMin =
    {1'b1, {(ese_pkg::DataW-1){1'b0}}};
  localparam logic signed [ese_pkg::DataW-1:0] ValMax =
    {1'b0, {(ese_pkg::DataW-1){1'b1}}};

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  ese_pkg::in_t  in_data   = '0;
  logic          out_ready = 1'b0;
  logic          in_ready;
  logic          out_valid;
  ese_pkg::out_t out_data;

  int fail_cnt, pending, results, sets, trimmed_sets;

  int items_sent = 0;
  int burst_left = 0;
  int stall_cyc  = 0;
  int ready_mode = 0;

  always #6 clk = ~clk;

  exchange_sort_engine_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  ese_checker u_ese_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .in_data_i      (in_data),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .out_data_i     (out_data),
    .fail_cnt_o     (fail_cnt),
    .pending_o      (pending),
    .results_o      (results),
    .sets_o         (sets),
    .trimmed_sets_o (trimmed_sets)
  );

  // Receiver: the stall style is picked again at random now and then, from
  // always ready (no backpressure at all) to mostly stalled.
  always @(posedge clk) begin
    stall_cyc <= stall_cyc + 1;
    if (stall_cyc % 64 == 0) ready_mode <= $urandom_range(0, 3);
    case (ready_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= (stall_cyc % 3) != 0;
      2:       out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // One input transaction. Ready is looked at on the falling edge, where it
  // is settled, and the transaction completes on the next rising edge.
  // The sender runs in bursts; at the end of a burst valid drops for a random
  // gap and the payload carries junk meanwhile.
  task automatic send(input logic signed [ese_pkg::DataW-1:0] v, input logic last);
    int gap;
    in_valid <= 1'b1;
    in_data  <= '{value: v, last_in: last};
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      in_data  <= '{value: $urandom, last_in: 1'($urandom_range(0, 1))};
      repeat (gap) @(posedge clk);
      // Now and then a long burst with no gaps at all.
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
  endtask

  // Value styles: 0 full-range random, 1 narrow band (many equal values),
  // otherwise a mix weighted toward the extremes of the signed range.
  function automatic logic signed [ese_pkg::DataW-1:0] pick_value(input int style);
    case (style)
      0: return $urandom;
      1: return ese_pkg::DataW'($urandom_range(0, 14)) - ese_pkg::DataW'(7);
      default: begin
        case ($urandom_range(0, 5))
          0:       return ValMin;
          1:       return ValMax;
          2:       return '0;
          3:       return '1;
          4:       return ValMin + ese_pkg::DataW'($urandom_range(0, 3));
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  // Mostly short sets, some up to a full chain, a few that overflow it.
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 11) return $urandom_range(1, 6);
    if (r < 14) return $urandom_range(7, ese_pkg::Depth - 1);
    if (r < 17) return ese_pkg::Depth;
    return $urandom_range(ese_pkg::Depth + 1, ese_pkg::Depth + 8);
  endfunction

  task automatic send_set(input int n, input int style);
    for (int i = 0; i < n; i++) send(pick_value(style), i == n - 1);
  endtask

  initial begin
    burst_left = $urandom_range(1, 8);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single-element set holding the most negative value.
    send(ValMin, 1'b1);
    // Both extremes, zero, and equal values in one set.
    send(ValMax, 1'b0);
    send(ValMin, 1'b0);
    send('1, 1'b0);
    send('0, 1'b0);
    send('1, 1'b0);
    send(ValMax, 1'b1);
    // Chain filled exactly, then the last element arrives and is dropped.
    for (int i = 0; i < ese_pkg::Depth; i++)
      send(ese_pkg::DataW'((i % 5) * 1000 - i), 1'b0);
    send(ValMin, 1'b1);

    while (items_sent < ItemTarget) send_set(pick_len(), $urandom_range(0, 2));
    in_valid <= 1'b0;

    // Let the last sets drain, then watch for stray results.
    do @(negedge clk); while (pending != 0);
    repeat (SettleCycles) @(posedge clk);

    $display("Run covered %0d input transactions in %0d sets, %0d of them overflowing;",
             items_sent, sets, trimmed_sets);
    $display("%0d sorted results were compared against the prediction.", results);
    if (fail_cnt == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog, far above the slowest legal run.
  initial begin
    #5_000_000;
    $display("Timeout: results still missing");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
